// ===== hdl/ttw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;

    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int ADDR_W      = 11;
    localparam int CELL_W      = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0]  CMD_PUT      = 2'd0;
    localparam logic [CMD_W-1:0]  CMD_CLEAR    = 2'd1;
    localparam logic [CMD_W-1:0]  CMD_READ     = 2'd2;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUT,
        OP_CLEAR,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic                do_write;
        logic [ADDR_W-1:0]   wr_addr;
        logic [CELL_W-1:0]   wr_data;
        logic                do_scroll;
        logic [ADDR_W-1:0]   rd_addr;
        logic                rd_ok;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [ADDR_W-1:0]   offset;
    } t_op;

endpackage

`default_nettype wire

// ===== hdl/ttw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ttw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttw_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ttw_pkg::CMD_W-1:0]     i_command,
    input  wire logic [ttw_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic [ttw_pkg::ATTR_W-1:0]    i_attribute,
    input  wire logic [ttw_pkg::ADDR_W-1:0]    i_cell_address,
    input  wire logic                          i_init_done,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output ttw_pkg::t_op                       o_op
);

    localparam int AW = ttw_pkg::ADDR_W;
    localparam int CW = ttw_pkg::COL_W;
    localparam int RW = ttw_pkg::ROW_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          accept;
    logic          wrap;
    logic [AW-1:0] cur_off;

    assign o_in_stall = !i_init_done || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept;
    assign cur_off    = AW'(AW'(r_row) * AW'(ttw_pkg::COLUMNS)) + AW'(r_col);

    always_comb begin
        n_col          = r_col;
        n_row          = r_row;
        wrap           = 1'b0;
        o_op           = '0;
        o_op.kind      = ttw_pkg::OP_NONE;
        o_op.wr_addr   = cur_off;
        o_op.wr_data   = {i_attribute, i_char_code};
        o_op.rd_addr   = i_cell_address;
        o_op.rd_ok     = i_cell_address < AW'(ttw_pkg::CELL_COUNT);
        case (i_command)
            ttw_pkg::CMD_PUT: begin
                o_op.kind = ttw_pkg::OP_PUT;
                if (i_char_code == ttw_pkg::NEWLINE_CODE) begin
                    wrap = 1'b1;
                end else begin
                    o_op.do_write = 1'b1;
                    if (r_col == CW'(ttw_pkg::COLUMNS - 1)) begin
                        wrap = 1'b1;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                if (wrap) begin
                    n_col = '0;
                    if (r_row >= RW'(ttw_pkg::ROWS - 3)) begin
                        o_op.do_scroll = 1'b1;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end
            end
            ttw_pkg::CMD_CLEAR: o_op.kind = ttw_pkg::OP_CLEAR;
            ttw_pkg::CMD_READ:  o_op.kind = ttw_pkg::OP_READ;
            default:            o_op.kind = ttw_pkg::OP_NONE;
        endcase
        o_op.col    = n_col;
        o_op.row    = n_row;
        o_op.offset = AW'(AW'(n_row) * AW'(ttw_pkg::COLUMNS)) + AW'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ttw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttw_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire ttw_pkg::t_op i_op,
    input  wire logic         i_pop,
    output ttw_pkg::t_op      o_head,
    output logic              o_full,
    output logic              o_empty
);

    localparam int DEPTH = ttw_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    ttw_pkg::t_op  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ttw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttw_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ttw_pkg::t_op                 i_head,
    input  wire logic                         i_q_empty,
    output logic                              o_pop,
    output logic                              o_init_done,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [ttw_pkg::COL_W-1:0]    o_cursor_col,
    output logic      [ttw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic      [ttw_pkg::ADDR_W-1:0]   o_cursor_offset,
    output logic      [ttw_pkg::CELL_W-1:0]   o_read_data
);

    localparam int AW = ttw_pkg::ADDR_W;
    localparam int DW = ttw_pkg::CELL_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_FILL,
        S_DONE
    } t_state;

    t_state        r_state;
    ttw_pkg::t_op  r_cur;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_cp_addr;
    logic          r_cp_pend;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic          out_free;
    logic          cnt_end;
    logic          fill_end;

    assign out_free    = !o_out_valid || !i_out_stall;
    assign cnt_end     = r_cnt == AW'(ttw_pkg::CELL_COUNT);
    assign fill_end    = r_cnt == AW'(ttw_pkg::CELL_COUNT - 1);
    assign o_init_done = r_state != S_INIT;

    ttw_ram #(
        .WIDTH (DW),
        .DEPTH (ttw_pkg::CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_cnt;
        o_pop     = 1'b0;
        case (r_state)
            S_INIT: ram_we = 1'b1;
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop     = 1'b1;
                    ram_we    = i_head.do_write;
                    ram_waddr = i_head.wr_addr;
                    ram_wdata = i_head.wr_data;
                    ram_re    = (i_head.kind == ttw_pkg::OP_READ) && i_head.rd_ok;
                    ram_raddr = i_head.rd_addr;
                end
            end
            S_SCROLL: begin
                ram_we    = r_cp_pend;
                ram_waddr = r_cp_addr;
                ram_wdata = ram_rdata;
                ram_re    = !cnt_end;
            end
            S_FILL:  ram_we = 1'b1;
            S_DONE:  ram_we = 1'b0;
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_cp_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (fill_end) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cur <= i_head;
                        if (i_head.kind == ttw_pkg::OP_PUT && i_head.do_scroll) begin
                            r_state <= S_SCROLL;
                            r_cnt   <= AW'(ttw_pkg::COLUMNS);
                        end else if (i_head.kind == ttw_pkg::OP_CLEAR) begin
                            r_state <= S_FILL;
                            r_cnt   <= '0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCROLL: begin
                    if (!cnt_end) begin
                        r_cp_pend <= 1'b1;
                        r_cp_addr <= r_cnt - AW'(ttw_pkg::COLUMNS);
                        r_cnt     <= r_cnt + AW'(1);
                    end else begin
                        r_cp_pend <= 1'b0;
                        r_state   <= S_FILL;
                        r_cnt     <= AW'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS);
                    end
                end
                S_FILL: begin
                    if (fill_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_cursor_col    <= r_cur.col;
                        o_cursor_row    <= r_cur.row;
                        o_cursor_offset <= r_cur.offset;
                        o_read_data     <= (r_cur.kind == ttw_pkg::OP_READ && r_cur.rd_ok)
                                           ? ram_rdata : '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/text_terminal_writer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Character-cell terminal writer: an 80 x 25 store of 16-bit cells (attribute in the
// upper byte, character in the lower byte) plus a cursor, updated by put-character,
// clear-screen and read-cell commands, one result per command carrying the cursor
// and its linear offset. After reset the input stalls while the store is cleared
// one cell per cycle. A put without scroll, a read, or an unused command goes from
// idle straight to the result state in the execution unit; a put that scrolls first
// moves every row up one row (one copy per cycle through the two-port store), then
// zeroes the last row, and a clear zeroes the store one cell per cycle. A two-entry
// command queue lets the input take commands while the unit is busy.
module text_terminal_writer_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [ttw_pkg::CMD_W-1:0]    i_command,
    input  wire logic [ttw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [ttw_pkg::ATTR_W-1:0]   i_attribute,
    input  wire logic [ttw_pkg::ADDR_W-1:0]   i_cell_address,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [ttw_pkg::COL_W-1:0]    o_cursor_col,
    output logic      [ttw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic      [ttw_pkg::ADDR_W-1:0]   o_cursor_offset,
    output logic      [ttw_pkg::CELL_W-1:0]   o_read_data
);

    ttw_pkg::t_op push_op;
    ttw_pkg::t_op head_op;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    logic         init_done;

    ttw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .i_cell_address (i_cell_address),
        .i_init_done    (init_done),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_op           (push_op)
    );

    ttw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ttw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_op),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_init_done     (init_done),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_offset (o_cursor_offset),
        .o_read_data     (o_read_data)
    );

endmodule

`default_nettype wire
